// ===== design/rhif_pkg.sv =====
// Shared types and constants for the ring-history IIR filter.
// Holds the command and result records passed between the front end,
// the queues and the tap engine. No dependencies.
package rhif_pkg;

  localparam int DATA_W     = 32;
  localparam int IDX_W      = 4;
  localparam int TERMS_W    = 5;
  localparam int MODE_W     = 2;
  localparam int ACC_W      = 52;
  localparam int FRAC_SHIFT = 20;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh0000_0000_8000_0000);
  localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [65:0] ROUND_HALF = 66'sd524288;

  localparam logic [MODE_W-1:0]  MODE_NONE   = 2'd0;
  localparam logic [MODE_W-1:0]  MODE_PASS   = 2'd1;
  localparam logic [MODE_W-1:0]  MODE_FILTER = 2'd2;
  localparam logic [TERMS_W-1:0] TERMS_RESET = 5'd1;

  localparam logic REG_FILTER_MODE = 1'b0;
  localparam logic REG_NUM_TERMS   = 1'b1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef enum logic [1:0] {
    OP_COEF  = 2'd0,
    OP_CONST = 2'd1,
    OP_FILT  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [DATA_W-1:0]  value;
    logic [TERMS_W-1:0]        taps;
    logic [IDX_W-1:0]          coef_idx;
    logic signed [DATA_W-1:0]  fwd;
    logic signed [DATA_W-1:0]  fbk;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     sat;
  } res_t;

endpackage

// ===== design/ring_history_iir_filter_top.sv =====
// Top level of the ring-history IIR filter.
// Instantiates rhif_front, two rhif_fifo queues and rhif_back; uses rhif_pkg.
//
//   channel   handshake             payload
//   input     push / full           in_kind, in_sample_value, in_coeff_index,
//                                   in_forward_coeff, in_feedback_coeff
//   result    empty / pop           out_filtered_value, out_saturated
//   config    psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// A filtered sample occupies the tap engine while the shared multiply-accumulate pipeline
// walks its taps; pass-through, none-mode samples and coefficient writes are handled
// directly from the idle state.
// Reset is synchronous; all history and coefficient entries read as zero after it.
// The command and result queues are two deep, so each side stalls independently.
module ring_history_iir_filter_top #(
  parameter int MAX_TERMS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                push,
  output logic                full,
  input  logic                in_kind,
  input  logic signed [31:0]  in_sample_value,
  input  logic [3:0]          in_coeff_index,
  input  logic signed [31:0]  in_forward_coeff,
  input  logic signed [31:0]  in_feedback_coeff,
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  out_filtered_value,
  output logic                out_saturated
);
  import rhif_pkg::*;

  cmd_t cmd_in, cmd_out;
  res_t res_in, res_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic res_push, res_full;

  rhif_front #(.MAX_TERMS(MAX_TERMS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .push              (push),
    .in_kind           (in_kind),
    .in_sample_value   (in_sample_value),
    .in_coeff_index    (in_coeff_index),
    .in_forward_coeff  (in_forward_coeff),
    .in_feedback_coeff (in_feedback_coeff),
    .cmd_full          (cmd_full),
    .cmd_push          (cmd_push),
    .cmd               (cmd_in)
  );

  rhif_fifo #(.W($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  rhif_back #(.MAX_TERMS(MAX_TERMS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  rhif_fifo #(.W($bits(res_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  // The input queue's fill state is the input channel's back-pressure.
  assign full               = cmd_full;
  assign out_filtered_value = res_out.value;
  assign out_saturated      = res_out.sat;

endmodule

// ===== design/rhif_fifo.sv =====
// Small register-based first-in first-out queue.
// Used for the command queue and the result queue; no package needed.
module rhif_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== design/rhif_front.sv =====
// Front end: configuration registers and request classification.
// Turns each accepted request into a command for the tap engine; uses rhif_pkg.
module rhif_front #(
  parameter int MAX_TERMS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                push,
  input  logic                in_kind,
  input  logic signed [31:0]  in_sample_value,
  input  logic [3:0]          in_coeff_index,
  input  logic signed [31:0]  in_forward_coeff,
  input  logic signed [31:0]  in_feedback_coeff,
  input  logic                cmd_full,
  output logic                cmd_push,
  output rhif_pkg::cmd_t      cmd
);
  import rhif_pkg::*;

  logic [MODE_W-1:0]  mode_r;
  logic [TERMS_W-1:0] terms_r;
  logic               cfg_wr;
  logic               accept;
  logic               idx_ok;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PASS;
      terms_r <= TERMS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FILTER_MODE: mode_r  <= pwdata[MODE_W-1:0];
        REG_NUM_TERMS:   terms_r <= pwdata[TERMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FILTER_MODE: prdata = 32'(mode_r);
      REG_NUM_TERMS:   prdata = 32'(terms_r);
      default:         prdata = '0;
    endcase
  end

  assign accept = push & ~cmd_full;
  assign idx_ok = (32'(in_coeff_index) < MAX_TERMS);

  // A coefficient write to a tap the block does not have is dropped here.
  assign cmd_push = accept && !(in_kind == KIND_COEF && !idx_ok);

  always_comb begin
    cmd.taps     = (32'(terms_r) > MAX_TERMS) ? TERMS_W'(MAX_TERMS) : terms_r;
    cmd.coef_idx = in_coeff_index;
    cmd.fwd      = in_forward_coeff;
    cmd.fbk      = in_feedback_coeff;
    case (mode_r)
      MODE_PASS: begin
        cmd.op    = OP_CONST;
        cmd.value = in_sample_value;
      end
      MODE_FILTER: begin
        cmd.op    = OP_FILT;
        cmd.value = in_sample_value;
      end
      default: begin
        cmd.op    = OP_CONST;
        cmd.value = '0;
      end
    endcase
    if (in_kind == KIND_COEF) begin
      cmd.op = OP_COEF;
    end
  end

endmodule

// ===== design/rhif_back.sv =====
// Tap engine: coefficient and history memories plus a shared
// multiply-accumulate pipeline that walks the taps. Uses rhif_pkg.
module rhif_back #(
  parameter int MAX_TERMS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_empty,
  input  rhif_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output rhif_pkg::res_t res
);
  import rhif_pkg::*;

  localparam int PW = $clog2(MAX_TERMS);
  localparam int TW = $clog2(MAX_TERMS + 1);
  localparam int SW = $clog2(2 * MAX_TERMS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [PW-1:0]     n_r, n_nxt;
  logic [PW-1:0]     i_r, i_nxt;
  logic [TW-1:0]     taps_r, taps_nxt;
  logic signed [DATA_W-1:0] sample_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [DATA_W-1:0] fwd_mem [MAX_TERMS];
  logic signed [DATA_W-1:0] fbk_mem [MAX_TERMS];
  logic signed [DATA_W-1:0] xh_mem  [MAX_TERMS];
  logic signed [DATA_W-1:0] yh_mem  [MAX_TERMS];
  logic [MAX_TERMS-1:0]     cv_r, xv_r, yv_r;

  logic signed [DATA_W-1:0] b_rd_r, a_rd_r, x_rd_r, y_rd_r;
  logic signed [63:0]       pb_r, pa_r;
  logic signed [ACC_W-1:0]  term_r;
  logic                     v1_r, v2_r, v3_r;
  logic                     last1_r, last2_r, last3_r;

  logic                     coef_we, x_we, y_we, issue, load;
  logic                     tap_last;
  logic [TW-1:0]            taps_in;
  logic [SW-1:0]            start_sum;
  logic [PW-1:0]            first_tap;
  logic [PW-1:0]            cidx;
  logic                     acc_hi, acc_lo;
  logic signed [DATA_W-1:0] acc_sat;
  logic signed [DATA_W-1:0] x_sel, y_sel;
  logic signed [65:0]       t_sum;

  // Saturated view of the running sum: feeds the newest tap and the result.
  assign acc_hi  = (acc_r > SAT_HI);
  assign acc_lo  = (acc_r < SAT_LO);
  assign acc_sat = acc_hi ? MAX_VAL : (acc_lo ? MIN_VAL : acc_r[DATA_W-1:0]);

  assign taps_in   = TW'(cmd.taps);
  assign start_sum = SW'(p_r) + SW'(MAX_TERMS + 1) - SW'(taps_in);
  assign first_tap = (start_sum >= SW'(MAX_TERMS)) ? PW'(start_sum - SW'(MAX_TERMS))
                                                   : PW'(start_sum);
  assign cidx      = PW'(cmd.coef_idx);
  assign tap_last  = (TW'(n_r) == taps_r - TW'(1));

  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    taps_nxt  = taps_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res.value = acc_sat;
    res.sat   = acc_hi | acc_lo;
    coef_we   = 1'b0;
    x_we      = 1'b0;
    y_we      = 1'b0;
    issue     = 1'b0;
    load      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.op)
            OP_COEF: begin
              coef_we = 1'b1;
              cmd_pop = 1'b1;
            end
            OP_CONST: begin
              if (!res_full) begin
                res_push  = 1'b1;
                cmd_pop   = 1'b1;
                res.value = cmd.value;
                res.sat   = 1'b0;
              end
            end
            OP_FILT: begin
              cmd_pop  = 1'b1;
              x_we     = 1'b1;
              load     = 1'b1;
              taps_nxt = taps_in;
              n_nxt    = '0;
              i_nxt    = first_tap;
              state_nxt = (cmd.taps == '0) ? S_DONE : S_ISSUE;
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      S_ISSUE: begin
        // The newest tap needs the sum of all older taps, so it waits
        // until the multiply and rounding stages have drained.
        if (!tap_last || (!v1_r && !v2_r)) begin
          issue = 1'b1;
          n_nxt = n_r + PW'(1);
          i_nxt = (i_r == PW'(MAX_TERMS - 1)) ? '0 : i_r + PW'(1);
          if (tap_last) begin
            state_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (v3_r && last3_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          y_we      = 1'b1;
          p_nxt     = (p_r == PW'(MAX_TERMS - 1)) ? '0 : p_r + PW'(1);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      p_r     <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      cv_r    <= '0;
      xv_r    <= '0;
      yv_r    <= '0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      if (coef_we) begin
        cv_r[cidx] <= 1'b1;
      end
      if (x_we) begin
        xv_r[p_r] <= 1'b1;
      end
      if (y_we) begin
        yv_r[p_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    taps_r  <= taps_nxt;
    last1_r <= issue & tap_last;
    last2_r <= last1_r;
    last3_r <= last2_r;
    if (load) begin
      sample_r <= cmd.value;
      acc_r    <= '0;
    end else if (v3_r) begin
      acc_r <= acc_r + term_r;
    end
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (coef_we) begin
      fwd_mem[cidx] <= cmd.fwd;
      fbk_mem[cidx] <= cmd.fbk;
    end
    if (x_we) begin
      xh_mem[p_r] <= cmd.value;
    end
    if (y_we) begin
      yh_mem[p_r] <= acc_sat;
    end
  end

  // Registered memory reads; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (issue) begin
      b_rd_r <= cv_r[n_r] ? fwd_mem[n_r] : '0;
      a_rd_r <= cv_r[n_r] ? fbk_mem[n_r] : '0;
      x_rd_r <= xv_r[i_r] ? xh_mem[i_r]  : '0;
      y_rd_r <= yv_r[i_r] ? yh_mem[i_r]  : '0;
    end
  end

  assign x_sel = last1_r ? sample_r : x_rd_r;
  assign y_sel = last1_r ? acc_sat  : y_rd_r;
  assign t_sum = 66'(pb_r) - 66'(pa_r) + ROUND_HALF;

  always_ff @(posedge clk) begin
    pb_r   <= 64'(b_rd_r) * 64'(x_sel);
    pa_r   <= 64'(a_rd_r) * 64'(y_sel);
    term_r <= ACC_W'(t_sum >>> FRAC_SHIFT);
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!v1_r && !v2_r && !v3_r))
    else $error("tap pipeline busy while engine idle");

  a_one_newest_tap: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({v1_r & last1_r, v2_r & last2_r, v3_r & last3_r}) <= 1)
    else $error("more than one newest tap in flight");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !res_full) |=> (p_r != $past(p_r)))
    else $error("write position did not advance after a filtered sample");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for ring_history_iir_filter_top: directed corner cases,
// then random request traffic under several idle and stall mixes.
// Depends on rhif_pkg and the design sources only.
module tb;
  import rhif_pkg::*;

  localparam int TAPS_MAX          = 16;
  localparam int DRAIN_CYCLES      = 60;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int ITEMS_PER_SEGMENT = 106;
  localparam logic signed [DATA_W-1:0] COEF_ONE = 32'sh0010_0000;

  typedef struct {
    logic                     kind;
    logic signed [DATA_W-1:0] sample;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] fwd;
    logic signed [DATA_W-1:0] fbk;
  } request_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                push = 1'b0;
  logic                full;
  logic                in_kind = KIND_SAMPLE;
  logic signed [31:0]  in_sample_value = '0;
  logic [3:0]          in_coeff_index = '0;
  logic signed [31:0]  in_forward_coeff = '0;
  logic signed [31:0]  in_feedback_coeff = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic signed [31:0]  out_filtered_value;
  logic                out_saturated;

  ring_history_iir_filter_top #(.MAX_TERMS(TAPS_MAX)) dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full),
    .in_kind(in_kind), .in_sample_value(in_sample_value),
    .in_coeff_index(in_coeff_index), .in_forward_coeff(in_forward_coeff),
    .in_feedback_coeff(in_feedback_coeff),
    .empty(empty), .pop(pop),
    .out_filtered_value(out_filtered_value), .out_saturated(out_saturated)
  );

  always #4 clk = ~clk;

  // Filter state as the block should hold it.
  logic signed [DATA_W-1:0] x_ring [TAPS_MAX];
  logic signed [DATA_W-1:0] y_ring [TAPS_MAX];
  logic signed [DATA_W-1:0] b_coef [TAPS_MAX];
  logic signed [DATA_W-1:0] a_coef [TAPS_MAX];
  int                       ring_pos;
  logic [MODE_W-1:0]        cur_mode;
  logic [TERMS_W-1:0]       cur_terms;

  res_t pending_results[$];
  res_t oldest_result;

  int send_idle_pct;
  int pop_stall_pct;
  int error_count;
  int cycle_count;
  int request_count;
  int coef_count;
  int result_count;
  int clip_count;
  int cfg_write_count;

  logic               seen_empty;
  logic signed [31:0] seen_value;
  logic               seen_sat;

  function automatic logic signed [DATA_W-1:0] clamp32(input longint v, output logic clipped);
    clipped = 1'b1;
    if (v > 64'sd2147483647) return MAX_VAL;
    if (v < -64'sd2147483648) return MIN_VAL;
    clipped = 1'b0;
    return v[DATA_W-1:0];
  endfunction

  // Work out what one accepted request produces and advance the filter state.
  function automatic void predict_filter(input request_t r);
    res_t               want;
    longint             acc;
    longint             term;
    int                 taps;
    int                 ring_i;
    logic signed [31:0] y_val;
    logic               clipped;
    if (r.kind == KIND_COEF) begin
      b_coef[r.idx] = r.fwd;
      a_coef[r.idx] = r.fbk;
      return;
    end
    want.value = '0;
    want.sat = 1'b0;
    case (cur_mode)
      MODE_PASS: want.value = r.sample;
      MODE_FILTER: begin
        taps = (cur_terms > TAPS_MAX) ? TAPS_MAX : int'(cur_terms);
        x_ring[ring_pos] = r.sample;
        acc = 0;
        for (int n = 0; n < taps; n++) begin
          ring_i = (ring_pos + TAPS_MAX + 1 - taps + n) % TAPS_MAX;
          // The newest tap feeds back the partial sum instead of a stored output.
          if (ring_i == ring_pos) y_val = clamp32(acc, clipped);
          else y_val = y_ring[ring_i];
          term = longint'(b_coef[n]) * longint'(x_ring[ring_i])
               - longint'(a_coef[n]) * longint'(y_val);
          acc += (term + (64'sd1 <<< 19)) >>> FRAC_SHIFT;
        end
        want.value = clamp32(acc, clipped);
        want.sat = clipped;
        y_ring[ring_pos] = want.value;
        ring_pos = (ring_pos + 1) % TAPS_MAX;
      end
      default: want.value = '0;
    endcase
    pending_results.push_back(want);
  endfunction

  // Result side: sample mid-cycle, check at the accepting edge, then pick the next pop.
  always @(negedge clk) begin
    seen_empty <= empty;
    seen_value <= out_filtered_value;
    seen_sat <= out_saturated;
  end

  always @(posedge clk) begin
    if (rst_n && pop && !seen_empty) begin
      if (pending_results.size() == 0) begin
        $error("filtered_value: no result expected, got %0d", seen_value);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        result_count++;
        if (seen_sat) clip_count++;
        if (seen_value !== oldest_result.value) begin
          $error("filtered_value: expected %0d, got %0d", oldest_result.value, seen_value);
          error_count++;
        end
        if (seen_sat !== oldest_result.sat) begin
          $error("saturated: expected %0d, got %0d", oldest_result.sat, seen_sat);
          error_count++;
        end
      end
    end
    pop <= rst_n && ($urandom_range(0, 99) >= pop_stall_pct);
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Called right after a rising edge; returns right after the accepting edge or a gap.
  task automatic send_request(input request_t r);
    push <= 1'b1;
    in_kind <= r.kind;
    in_sample_value <= r.sample;
    in_coeff_index <= r.idx;
    in_forward_coeff <= r.fwd;
    in_feedback_coeff <= r.fbk;
    do @(negedge clk); while (full);
    @(posedge clk);
    predict_filter(r);
    request_count++;
    if (r.kind == KIND_COEF) coef_count++;
    // Each following cycle is idle with the phase's probability.
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic request_t make_request(input logic kind, input logic signed [31:0] sample,
                                            input logic [3:0] idx, input logic signed [31:0] fwd,
                                            input logic signed [31:0] fbk);
    request_t r;
    r.kind = kind;
    r.sample = sample;
    r.idx = idx;
    r.fwd = fwd;
    r.fbk = fbk;
    return r;
  endfunction

  task automatic send_sample(input logic signed [31:0] v);
    send_request(make_request(KIND_SAMPLE, v, '0, '0, '0));
  endtask

  task automatic load_coeffs(input logic [3:0] idx, input logic signed [31:0] b,
                             input logic signed [31:0] a);
    send_request(make_request(KIND_COEF, '0, idx, b, a));
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic settle();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic reg_sel, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] stored;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (reg_sel == REG_FILTER_MODE) begin
      cur_mode = value[MODE_W-1:0];
      stored = 32'(value[MODE_W-1:0]);
    end else begin
      cur_terms = value[TERMS_W-1:0];
      stored = 32'(value[TERMS_W-1:0]);
    end
    cfg_write_count++;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    readback = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== stored) begin
      $error("register %0d readback: expected %0d, got %0d", reg_sel, stored, readback);
      error_count++;
    end
  endtask

  function automatic logic signed [31:0] around_zero(input int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return v;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) r.sample = around_zero(1 << 20);
    else if (roll < 75) r.sample = $urandom();
    else if (roll < 85) r.sample = around_zero(1 << 26);
    else begin
      case ($urandom_range(0, 3))
        0: r.sample = MAX_VAL;
        1: r.sample = MIN_VAL;
        2: r.sample = '0;
        default: r.sample = -32'sd1;
      endcase
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) r.fwd = around_zero(1 << 21);
    else if (roll < 75) r.fwd = $urandom();
    else if (roll < 90) r.fwd = COEF_ONE;
    else r.fwd = '0;
    // Small feedback keeps most runs away from runaway growth.
    roll = $urandom_range(0, 99);
    if (roll < 70) r.fbk = around_zero(1 << 18);
    else if (roll < 85) r.fbk = $urandom();
    else r.fbk = '0;
    r.idx = IDX_W'($urandom_range(0, 15));
    r.kind = ($urandom_range(0, 99) < 15) ? KIND_COEF : KIND_SAMPLE;
    return r;
  endfunction

  task automatic test_pass_through();
    send_sample(MAX_VAL);
    send_sample(MIN_VAL);
    send_sample('0);
    send_sample(-32'sd1);
    send_sample(32'sh5555_5555);
    load_coeffs(4'd15, MIN_VAL, MAX_VAL);
    settle();
  endtask

  task automatic test_quiet_modes();
    write_cfg(REG_FILTER_MODE, 32'(MODE_NONE));
    send_sample(MAX_VAL);
    send_sample(MIN_VAL);
    settle();
    // Mode 3 is undefined and behaves like none.
    write_cfg(REG_FILTER_MODE, 32'h0000_0003);
    send_sample(-32'sd1);
    settle();
  endtask

  task automatic test_filter_corners();
    write_cfg(REG_FILTER_MODE, 32'(MODE_FILTER));
    write_cfg(REG_NUM_TERMS, 32'd0);
    send_sample(32'sh1234_5678);
    settle();
    write_cfg(REG_NUM_TERMS, 32'd1);
    load_coeffs(4'd0, COEF_ONE, '0);
    send_sample(MAX_VAL);
    send_sample(MIN_VAL);
    load_coeffs(4'd0, MAX_VAL, MIN_VAL);
    send_sample(MAX_VAL);
    send_sample(MIN_VAL);
    settle();
    // All ones in the count field asks for more taps than exist.
    write_cfg(REG_NUM_TERMS, 32'hFFFF_FFFF);
    load_coeffs(4'd15, COEF_ONE, COEF_ONE >>> 1);
    load_coeffs(4'd14, -COEF_ONE, MIN_VAL);
    send_sample(32'sh0001_0000);
    send_sample(-32'sh0003_0000);
    settle();
  endtask

  task automatic test_random_traffic();
    int idle_pct [4] = '{0, 69, 0, 22};
    int stall_pct [4] = '{0, 0, 69, 22};
    int seg_mode [8] = '{2, 2, 1, 2, 0, 2, 3, 2};
    int seg_terms [8] = '{16, 1, 7, 31, 3, 0, 5, 9};
    int seg;
    for (int ph = 0; ph < 4; ph++) begin
      for (int s = 0; s < 2; s++) begin
        seg = ph * 2 + s;
        settle();
        send_idle_pct = idle_pct[ph];
        pop_stall_pct = stall_pct[ph];
        write_cfg(REG_FILTER_MODE, ($urandom() & ~32'h3) | 32'(seg_mode[seg]));
        write_cfg(REG_NUM_TERMS, ($urandom() & ~32'h1F) | 32'(seg_terms[seg]));
        for (int k = 0; k < ITEMS_PER_SEGMENT; k++) begin
          send_request(random_request());
          if ($urandom_range(0, 79) == 0) wait_for_results();
        end
      end
    end
    settle();
  endtask

  initial begin
    foreach (x_ring[i]) begin
      x_ring[i] = '0;
      y_ring[i] = '0;
      b_coef[i] = '0;
      a_coef[i] = '0;
    end
    ring_pos = 0;
    cur_mode = MODE_PASS;
    cur_terms = TERMS_RESET;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    error_count = 0;
    cycle_count = 0;
    request_count = 0;
    coef_count = 0;
    result_count = 0;
    clip_count = 0;
    cfg_write_count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_pass_through();
    test_quiet_modes();
    test_filter_corners();
    test_random_traffic();
    $display("Sent %0d requests (%0d coefficient loads) and %0d register writes.",
             request_count, coef_count, cfg_write_count);
    $display("Checked %0d results over four idle/stall mixes, %0d of them clipped.",
             result_count, clip_count);
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
